[hdl/pff_pkg.sv]
// ----------------------------------------------------------------------------
// Printf field formatter package
// Conversion codes, default bounds and the plan handed to the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pff_pkg;

  localparam int MAX_WIDTH_DEF     = 48;
  localparam int MAX_PRECISION_DEF = 32;

  typedef enum logic [2:0] {
    OP_D   = 3'd0,
    OP_U   = 3'd1,
    OP_X   = 3'd2,
    OP_XU  = 3'd3,
    OP_P   = 3'd4,
    OP_C   = 3'd5,
    OP_PCT = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  // Everything the emitter needs to walk one field.
  typedef struct packed {
    logic [5:0]  lead;    // leading spaces
    logic [39:0] pfx;     // literal characters, first one in the top byte
    logic [2:0]  plen;
    logic [6:0]  zfill;   // zeros between the literal and the digits
    logic [63:0] digits;  // digit nibbles, most significant in the top nibble
    logic [4:0]  ndig;
    logic        upper;
    logic [6:0]  total;   // characters in the whole field
  } plan_t;

endpackage

[hdl/pff_conv.sv]
// ----------------------------------------------------------------------------
// Digit converter
// Turns a magnitude into hex or decimal digits, one bit or one digit a cycle,
// and left-aligns them so that the leading digit sits in the top nibble.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pff_conv
  import pff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        hex,
  input  logic [63:0] mag,
  output logic        done,
  output logic [63:0] digits,
  output logic [4:0]  ndig
);

  typedef enum logic [1:0] {S_IDLE, S_DAB, S_NORM} state_t;

  state_t      state_r;
  logic [31:0] sh_r;
  logic [39:0] bcd_r;
  logic [5:0]  cnt_r;
  logic [63:0] dig_r;
  logic [4:0]  ndig_r;
  logic        done_r;
  logic [39:0] adj;

  // Add-3 correction on every BCD digit before the shift.
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                : bcd_r[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ndig_r <= 5'd16;
            if (hex) begin
              dig_r   <= mag;
              state_r <= S_NORM;
            end else begin
              sh_r    <= mag[31:0];
              bcd_r   <= '0;
              cnt_r   <= 6'd32;
              state_r <= S_DAB;
            end
          end
        end
        S_DAB: begin
          bcd_r <= {adj[38:0], sh_r[31]};
          sh_r  <= {sh_r[30:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            dig_r   <= {24'd0, adj[38:0], sh_r[31]};
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (ndig_r != 5'd0 && dig_r[63:60] == 4'd0) begin
            dig_r  <= {dig_r[59:0], 4'd0};
            ndig_r <= ndig_r - 5'd1;
          end else begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign digits = dig_r;
  assign ndig   = ndig_r;

endmodule

[hdl/pff_emit.sv]
// ----------------------------------------------------------------------------
// Character emitter
// Walks a field plan and sends one character per beat through an output
// register: leading spaces, literal, zeros, digits, trailing spaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pff_emit
  import pff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  plan_t      plan,
  output logic       busy,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic [6:0]  rem_r;
  logic [5:0]  lead_r;
  logic [39:0] pfx_r;
  logic [2:0]  plen_r;
  logic [6:0]  zf_r;
  logic [63:0] dig_r;
  logic [4:0]  ndig_r;
  logic        upper_r;
  logic        valid_r;
  logic [7:0]  char_r;
  logic        last_r;
  logic        adv;
  logic [3:0]  d;
  logic [7:0]  dchar;

  assign adv = (rem_r != 7'd0) && (!valid_r || out_tready);
  assign d   = dig_r[63:60];

  always_comb begin
    if (d < 4'd10) dchar = 8'h30 + {4'd0, d};
    else           dchar = (upper_r ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (start) begin
        rem_r   <= plan.total;
        lead_r  <= plan.lead;
        pfx_r   <= plan.pfx;
        plen_r  <= plan.plen;
        zf_r    <= plan.zfill;
        dig_r   <= plan.digits;
        ndig_r  <= plan.ndig;
        upper_r <= plan.upper;
      end else if (adv) begin
        rem_r   <= rem_r - 7'd1;
        valid_r <= 1'b1;
        last_r  <= (rem_r == 7'd1);
        if (lead_r != 6'd0) begin
          char_r <= 8'h20;
          lead_r <= lead_r - 6'd1;
        end else if (plen_r != 3'd0) begin
          char_r <= pfx_r[39:32];
          pfx_r  <= {pfx_r[31:0], 8'd0};
          plen_r <= plen_r - 3'd1;
        end else if (zf_r != 7'd0) begin
          char_r <= 8'h30;
          zf_r   <= zf_r - 7'd1;
        end else if (ndig_r != 5'd0) begin
          char_r <= dchar;
          dig_r  <= {dig_r[59:0], 4'd0};
          ndig_r <= ndig_r - 5'd1;
        end else begin
          char_r <= 8'h20;
        end
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign busy       = (rem_r != 7'd0) || valid_r;
  assign out_tvalid = valid_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

endmodule

[hdl/printf_field_formatter.sv]
// ----------------------------------------------------------------------------
// Printf field formatter
// Formats one parsed integer-style printf conversion into ASCII characters.
// ----------------------------------------------------------------------------
// One conversion is taken at a time. After the input beat the digit converter
// runs bit-serial binary to BCD (decimal) or loads the value as it is (hex),
// then left-aligns the digits, one digit a cycle; the planning state S_LOAD
// follows, then the field leaves at one character per beat while out_tready
// is high. The field is at most MAX_WIDTH long or, where that is shorter,
// the prefix plus the digits or the precision, whichever is longer.
// in_tready rises again once the last character has been taken.
`timescale 1ns / 1ps

module printf_field_formatter
  import pff_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], arg_value[66:3], plus_flag[67], space_flag[68], alt_flag[69],
  // left_flag[70], zero_flag[71], has_precision[72], precision[78:73],
  // width[84:79], zeros above
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_char[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_LOAD, S_EMIT} state_t;

  state_t      state_r;
  op_t         op_r;
  logic        plus_r, space_r, alt_r, left_r, zero_r, hp_r, neg_r, argz_r;
  logic [5:0]  prec_r, wid_r;
  logic [7:0]  ch_r;

  logic [2:0]  in_op;
  logic [63:0] in_arg;
  logic [31:0] lo;
  logic [63:0] mag;
  logic        hex;
  logic        acc;
  logic        conv_done;
  logic [63:0] conv_dig;
  logic [4:0]  conv_ndig;
  logic        emit_start;
  logic        emit_busy;
  plan_t       plan;

  assign in_op  = in_tdata[2:0];
  assign in_arg = in_tdata[66:3];
  assign lo     = in_arg[31:0];
  assign acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    hex = 1'b0;
    mag = '0;
    case (in_op)
      OP_D:         mag = {32'd0, lo[31] ? 32'd0 - lo : lo};
      OP_U:         mag = {32'd0, lo};
      OP_X, OP_XU:  begin mag = {32'd0, lo}; hex = 1'b1; end
      OP_P:         begin mag = in_arg;      hex = 1'b1; end
      default:      mag = '0;
    endcase
  end

  pff_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (acc),
    .hex    (hex),
    .mag    (mag),
    .done   (conv_done),
    .digits (conv_dig),
    .ndig   (conv_ndig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            op_r    <= op_t'(in_op);
            plus_r  <= in_tdata[67];
            space_r <= in_tdata[68];
            alt_r   <= in_tdata[69];
            left_r  <= in_tdata[70];
            zero_r  <= in_tdata[71];
            hp_r    <= in_tdata[72];
            prec_r  <= (in_tdata[78:73] > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                             : in_tdata[78:73];
            wid_r   <= (in_tdata[84:79] > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                         : in_tdata[84:79];
            neg_r   <= lo[31];
            argz_r  <= (in_arg == 64'd0);
            ch_r    <= in_arg[7:0];
            state_r <= S_CONV;
          end
        end
        S_CONV: if (conv_done) state_r <= S_LOAD;
        S_LOAD: state_r <= S_EMIT;
        S_EMIT: if (!emit_busy) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign emit_start = (state_r == S_LOAD);

  // Field plan from the captured flags and the converted digits.
  logic [39:0] pfx;
  logic [2:0]  plen;
  logic [4:0]  nd;
  logic [5:0]  n;
  logic        numeric, pad_ok, zpad;
  logic [7:0]  sgn;
  logic        has_sgn;
  logic [6:0]  body;
  logic [5:0]  pad;

  always_comb begin
    has_sgn = 1'b1;
    sgn     = 8'h2B;
    if (op_r == OP_D && neg_r) sgn = 8'h2D;
    else if (plus_r)           sgn = 8'h2B;
    else if (space_r)          sgn = 8'h20;
    else                       has_sgn = 1'b0;

    pfx     = '0;
    plen    = 3'd0;
    numeric = 1'b1;
    pad_ok  = 1'b1;
    case (op_r)
      OP_D: begin
        if (has_sgn) begin pfx = {sgn, 32'd0}; plen = 3'd1; end
      end
      OP_X, OP_XU: begin
        // Hex looks only at the low word, so a zero there drops the prefix.
        if (alt_r && conv_ndig != 5'd0) begin
          pfx  = {8'h30, (op_r == OP_XU) ? 8'h58 : 8'h78, 24'd0};
          plen = 3'd2;
        end
      end
      OP_P: begin
        if (argz_r) begin
          pfx     = {8'h28, 8'h6E, 8'h69, 8'h6C, 8'h29};
          plen    = 3'd5;
          numeric = 1'b0;
        end else if (has_sgn) begin
          pfx = {sgn, 8'h30, 8'h78, 16'd0}; plen = 3'd3;
        end else begin
          pfx = {8'h30, 8'h78, 24'd0};      plen = 3'd2;
        end
      end
      OP_C: begin
        pfx = {ch_r, 32'd0}; plen = 3'd1; numeric = 1'b0;
      end
      OP_PCT: begin
        pfx = {8'h25, 32'd0}; plen = 3'd1; numeric = 1'b0; pad_ok = 1'b0;
      end
      OP_NONE: begin
        numeric = 1'b0; pad_ok = 1'b0;
      end
      default: ;
    endcase

    nd = conv_ndig;
    if (conv_ndig == 5'd0 && !(hp_r && prec_r == 6'd0)) nd = 5'd1;
    if (!numeric) nd = 5'd0;
    n = {1'b0, nd};
    if (numeric && hp_r && prec_r > n) n = prec_r;

    body = {4'd0, plen} + {1'b0, n};
    pad  = (pad_ok && {1'b0, wid_r} > body) ? wid_r - body[5:0] : 6'd0;
    zpad = numeric && zero_r && !hp_r && !left_r;

    plan.lead   = (!left_r && !zpad) ? pad : 6'd0;
    plan.pfx    = pfx;
    plan.plen   = plen;
    plan.zfill  = (zpad ? {1'b0, pad} : 7'd0) + {1'b0, n - {1'b0, nd}};
    plan.digits = conv_dig;
    plan.ndig   = nd;
    plan.upper  = (op_r == OP_XU);
    plan.total  = body + {1'b0, pad};
  end

  pff_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .plan       (plan),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Printf field formatter testbench
// Drives parsed conversions with random idling on both sides and checks every
// emitted character and last marker against a behavioral formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pff_pkg::*;

  typedef struct {
    op_t         op;
    logic [63:0] arg;
    logic        plus, space, alt, left, zero, has_prec;
    logic [5:0]  prec, wid;
  } conv_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  conv_t pending_convs[$];
  char_t expected_chars[$];
  int    errors = 0;
  int    cycle_count = 0;
  bit    hold_sender = 1'b0;
  bit    no_idle = 1'b0;
  bit    stimulus_done = 1'b0;

  printf_field_formatter i_dut (.*);

  always #10 clk = ~clk;

  function automatic logic [87:0] pack_conv(conv_t c);
    return {3'b000, c.wid, c.prec, c.has_prec, c.zero, c.left, c.alt, c.space,
            c.plus, c.arg, c.op};
  endfunction

  task automatic put_char(input logic [7:0] ch);
    char_t e;
    e.ch = ch;
    e.last = 1'b0;
    expected_chars.push_back(e);
  endtask

  task automatic put_many(input logic [7:0] ch, input int n);
    for (int i = 0; i < n; i++) put_char(ch);
  endtask

  // Appends the characters of one formatted field to the expected queue.
  task automatic format_field(input conv_t c);
    int          wid, prec, pad, n, ndig, start;
    logic [7:0]  pfx[$];
    logic [7:0]  dig[$];
    logic [63:0] mag;
    logic [31:0] v;
    int          base;
    bit          upper;
    string       nil;
    start = expected_chars.size();
    wid = (c.wid > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : c.wid;
    prec = (c.prec > MAX_PRECISION_DEF) ? MAX_PRECISION_DEF : c.prec;
    nil = "(nil)";
    base = 10;
    upper = 1'b0;
    mag = '0;
    case (c.op)
      OP_NONE: return;
      OP_PCT: begin
        put_char("%");
      end
      OP_C: begin
        pad = (wid > 1) ? wid - 1 : 0;
        if (!c.left) put_many(" ", pad);
        put_char(c.arg[7:0]);
        if (c.left) put_many(" ", pad);
      end
      default: begin
        if (c.op == OP_P && c.arg == 0) begin
          pad = (wid > 5) ? wid - 5 : 0;
          if (!c.left) put_many(" ", pad);
          for (int i = 0; i < 5; i++) put_char(nil[i]);
          if (c.left) put_many(" ", pad);
        end else begin
          case (c.op)
            OP_D: begin
              v = c.arg[31:0];
              if (v[31]) begin
                pfx.push_back("-");
                v = 32'd0 - v;
                mag = {32'd0, v};
              end else begin
                mag = {32'd0, v};
                if (c.plus) pfx.push_back("+");
                else if (c.space) pfx.push_back(" ");
              end
            end
            OP_U: mag = 64'(c.arg[31:0]);
            OP_X, OP_XU: begin
              mag = 64'(c.arg[31:0]);
              base = 16;
              upper = (c.op == OP_XU);
              if (c.alt && mag != 0) begin
                pfx.push_back("0");
                pfx.push_back(upper ? "X" : "x");
              end
            end
            default: begin
              mag = c.arg;
              base = 16;
              if (c.plus) pfx.push_back("+");
              else if (c.space) pfx.push_back(" ");
              pfx.push_back("0");
              pfx.push_back("x");
            end
          endcase
          while (mag != 0) begin
            int d;
            d = int'(mag % base);
            dig.push_front(d < 10 ? 8'("0" + d) : 8'((upper ? "A" : "a") + d - 10));
            mag = mag / base;
          end
          if (dig.size() == 0 && !(c.has_prec && prec == 0)) dig.push_back("0");
          ndig = dig.size();
          n = (c.has_prec && prec > ndig) ? prec : ndig;
          pad = (wid > pfx.size() + n) ? wid - pfx.size() - n : 0;
          if (!c.left && !(c.zero && !c.has_prec)) put_many(" ", pad);
          foreach (pfx[i]) put_char(pfx[i]);
          if (!c.left && c.zero && !c.has_prec) put_many("0", pad);
          put_many("0", n - ndig);
          foreach (dig[i]) put_char(dig[i]);
          if (c.left) put_many(" ", pad);
        end
      end
    endcase
    if (expected_chars.size() > start) expected_chars[$].last = 1'b1;
  endtask

  function automatic conv_t rand_conv();
    conv_t c;
    c.op = op_t'($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0: c.arg = '0;
      1: c.arg = {$urandom, $urandom};
      2: c.arg = 64'($urandom_range(0, 300));
      3: c.arg = {$urandom, 32'h8000_0000 | $urandom_range(0, 3)};
      default: c.arg = {32'($urandom), 32'($urandom)};
    endcase
    {c.plus, c.space, c.alt, c.left, c.zero, c.has_prec} = 6'($urandom);
    c.prec = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    c.wid = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 20));
    return c;
  endfunction

  // Sender.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        format_field(pending_convs.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_convs.size() > 0 && !hold_sender &&
            (no_idle || $urandom_range(0, 99) >= 23)) begin
          in_tvalid <= 1'b1;
          in_tdata <= pack_conv(pending_convs[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %h", out_tdata);
          errors++;
        end else begin
          char_t e;
          e = expected_chars.pop_front();
          if (out_tdata !== e.ch) begin
            $error("out_char expected %h actual %h", e.ch, out_tdata);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last_char expected %b actual %b", e.last, out_tlast);
            errors++;
          end
        end
      end
      out_tready <= no_idle || $urandom_range(0, 99) >= 23;
    end
  end

  initial begin
    conv_t c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, every conversion and the special cases.
    for (int op = 0; op < 8; op++) begin
      c = '{op_t'(op), 64'hFFFF_FFFF_8000_0000, 1, 1, 1, 0, 1, 0, 0, 12};
      pending_convs.push_back(c);
    end
    pending_convs.push_back('{OP_D, 64'h0, 0, 1, 0, 0, 0, 1, 0, 5});
    pending_convs.push_back('{OP_X, 64'h0, 0, 0, 1, 1, 0, 1, 0, 4});
    pending_convs.push_back('{OP_XU, 64'hABCD, 0, 0, 1, 0, 1, 0, 0, 10});
    pending_convs.push_back('{OP_X, 64'h7FFF_FFFF, 0, 0, 0, 0, 1, 0, 0, 10});
    pending_convs.push_back('{OP_P, 64'h0, 1, 1, 0, 1, 1, 1, 3, 9});
    pending_convs.push_back('{OP_P, 64'h0, 0, 0, 0, 0, 0, 0, 0, 63});
    pending_convs.push_back('{OP_P, '1, 0, 1, 0, 0, 1, 0, 0, 63});
    pending_convs.push_back('{OP_U, 64'hFFFF_FFFF, 1, 1, 0, 0, 0, 1, 63, 63});
    pending_convs.push_back('{OP_D, 64'h7FFF_FFFF, 1, 0, 0, 1, 0, 1, 33, 49});
    pending_convs.push_back('{OP_D, 64'h1, 0, 1, 0, 0, 1, 0, 0, 6});
    pending_convs.push_back('{OP_C, 64'hFF, 0, 0, 0, 1, 1, 1, 5, 4});
    pending_convs.push_back('{OP_U, 64'h0, 0, 0, 0, 0, 0, 1, 0, 0});
    pending_convs.push_back('{OP_PCT, 64'h0, 1, 1, 1, 1, 1, 1, 40, 40});
    wait (pending_convs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_chars.size() == 0);
    hold_sender = 1'b0;
    for (int i = 0; i < 150; i++) begin
      if (i == 60) begin
        wait (pending_convs.size() == 0);
        no_idle = 1'b1;
      end
      if (i == 90) begin
        wait (pending_convs.size() == 0);
        no_idle = 1'b0;
      end
      pending_convs.push_back(rand_conv());
    end
    wait (pending_convs.size() == 0 && !in_tvalid);
    wait (expected_chars.size() == 0);
    repeat (200) @(posedge clk);
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done || cycle_count > 400000);
    if (stimulus_done && errors == 0) begin
      $display("[printf_field_formatter] OK");
    end else begin
      $display("[printf_field_formatter] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pff_pkg.sv
hdl/pff_conv.sv
hdl/pff_emit.sv
hdl/printf_field_formatter.sv
sim/testbench.sv
